// ===== rtl/rlpc_pkg.sv =====
// Shared types, character codes and lookup functions for the RGB LED PWM command controller.
package rlpc_pkg;

    localparam int LEVEL_W  = 7;
    localparam int DELAY_W  = 34;
    localparam int TICK_W   = 16;
    localparam int BYTE_W   = 8;
    localparam int SEL_W    = 2;
    localparam int DIGIT_W  = 4;
    localparam int FIFO_DEPTH = 2;

    localparam logic [TICK_W-1:0]  TICK_RESET  = 16'd100;
    localparam logic [DELAY_W-1:0] DELAY_RESET = 34'd100000;

    localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;
    localparam logic [BYTE_W-1:0] CH_NL    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_R     = 8'h52;
    localparam logic [BYTE_W-1:0] CH_G     = 8'h47;
    localparam logic [BYTE_W-1:0] CH_B     = 8'h42;
    localparam logic [BYTE_W-1:0] CH_A     = 8'h41;
    localparam logic [BYTE_W-1:0] CH_E     = 8'h45;
    localparam logic [BYTE_W-1:0] CH_N     = 8'h4E;
    localparam logic [BYTE_W-1:0] CH_F     = 8'h46;
    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CH_ONE   = 8'h31;
    localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;

    localparam logic [SEL_W-1:0] SEL_RED   = 2'd0;
    localparam logic [SEL_W-1:0] SEL_GREEN = 2'd1;
    localparam logic [SEL_W-1:0] SEL_BLUE  = 2'd2;

    typedef enum logic [1:0] {
        ST_OK,
        ST_BAD_CHAN,
        ST_BAD_SECOND,
        ST_BAD_DIGIT
    } status_t;

    typedef enum logic [1:0] {
        OP_TICK,
        OP_NOP,
        OP_CMD
    } op_kind_t;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_RAMP_ON,
        CMD_RAMP_OFF,
        CMD_DELAY,
        CMD_POWER
    } cmd_t;

    typedef struct packed {
        op_kind_t             kind;
        cmd_t                 cmd;
        status_t              status;
        logic                 all;
        logic [SEL_W-1:0]     sel;
        logic [DIGIT_W-1:0]   mant;
        logic [DIGIT_W-1:0]   expo;
        logic [LEVEL_W-1:0]   power;
    } op_t;

    function automatic logic is_digit(input logic [BYTE_W-1:0] b);
        return (b >= CH_ZERO) && (b <= CH_NINE);
    endfunction

    function automatic logic [DELAY_W-1:0] pow10(input logic [DIGIT_W-1:0] p);
        logic [DELAY_W-1:0] r;
        case (p)
            4'd0:    r = 34'd1;
            4'd1:    r = 34'd10;
            4'd2:    r = 34'd100;
            4'd3:    r = 34'd1000;
            4'd4:    r = 34'd10000;
            4'd5:    r = 34'd100000;
            4'd6:    r = 34'd1000000;
            4'd7:    r = 34'd10000000;
            4'd8:    r = 34'd100000000;
            4'd9:    r = 34'd1000000000;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/rlpc_if.sv =====
// Handshake channel interfaces: request, result and configuration write.
interface rlpc_req_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] rx_byte;

    modport source (output valid, output req_type, output rx_byte, input ready);
    modport sink   (input valid, input req_type, input rx_byte, output ready);
endinterface

interface rlpc_rsp_if;
    logic       valid;
    logic       ready;
    logic       led_red;
    logic       led_green;
    logic       led_blue;
    logic       cmd_done;
    logic [1:0] cmd_status;

    modport source (output valid, output led_red, output led_green, output led_blue,
                    output cmd_done, output cmd_status, input ready);
    modport sink   (input valid, input led_red, input led_green, input led_blue,
                    input cmd_done, input cmd_status, output ready);
endinterface

interface rlpc_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] tick_period_us;

    modport source (output valid, output tick_period_us, input ready);
    modport sink   (input valid, input tick_period_us, output ready);
endinterface

// ===== rtl/rgb_led_pwm_command_controller_top.sv =====
// Top level of the RGB LED PWM command controller: front end, op queue and back end.
// Three-channel LED dimmer. Each request transfer is either a PWM tick (req_type 0) or a
// command byte (req_type 1), and every request gives exactly one result transfer, in order.
// A ':' opens a message; MSG_LEN bytes or a newline close it, and the closing transfer
// reports cmd_done with cmd_status (0 ok, 1 bad channel letter, 2 bad second character,
// 3 bad digit). Messages: "xEN"/"xEF" switch the breathing ramp on/off, "xEdp" sets the
// ramp delay to d*10^p us, "x0dd"/"x1dd" set power saturated at PWM_STEPS, where x is
// R, G, B or A (all). A tick drives the LED outputs from phase < power, advances the
// phase modulo PWM_STEPS and spends tick_period_us of ramp delay; each elapsed delay
// writes the ramp level into the next enabled channel. Throughput is one request per clock
// while results are taken: the front end decodes a byte in the cycle it is accepted, a
// two-entry op queue decouples it from the back end, and the back end executes one op per
// cycle into a result register unless an untaken result holds it. Ops go through the queue
// even when it is empty. A stalled result fills the queue, after which req.ready drops.
// tick_period_us (reset 100) is written through the cfg channel, which is always ready;
// write it only while no request is outstanding. No clearing pass after reset.
module rgb_led_pwm_command_controller_top #(
    parameter int NUM_CHANNELS = 3,
    parameter int MSG_LEN      = 5,
    parameter int PWM_STEPS    = 100
) (
    input  logic       clk,
    input  logic       rst_n,
    rlpc_req_if.sink   req,
    rlpc_rsp_if.source rsp,
    rlpc_cfg_if.sink   cfg
);
    import rlpc_pkg::*;

    // decoded op from the front end into the queue
    op_t  front_op;
    logic front_valid;
    logic front_ready;

    // queue head into the back end
    op_t  back_op;
    logic back_valid;
    logic back_ready;

    rlpc_front #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .MSG_LEN      (MSG_LEN),
        .PWM_STEPS    (PWM_STEPS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .op       (front_op),
        .op_valid (front_valid),
        .op_ready (front_ready)
    );

    rlpc_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_data  (front_op),
        .wr_valid (front_valid),
        .wr_ready (front_ready),
        .rd_data  (back_op),
        .rd_valid (back_valid),
        .rd_ready (back_ready)
    );

    // back end owns all LED, ramp and config state plus the result register
    rlpc_back #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .PWM_STEPS    (PWM_STEPS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .op       (back_op),
        .op_valid (back_valid),
        .op_ready (back_ready),
        .cfg      (cfg),
        .rsp      (rsp)
    );

endmodule

// ===== rtl/rlpc_front.sv =====
// Front end: takes request transfers, assembles messages and decodes them into ops.
module rlpc_front #(
    parameter int NUM_CHANNELS = 3,
    parameter int MSG_LEN      = 5,
    parameter int PWM_STEPS    = 100
) (
    input  logic           clk,
    input  logic           rst_n,
    rlpc_req_if.sink       req,
    output rlpc_pkg::op_t  op,
    output logic           op_valid,
    input  logic           op_ready
);
    import rlpc_pkg::*;

    localparam int CNT_W = $clog2(MSG_LEN);
    localparam int KEEP  = 4;   // only the first four bytes are interpreted

    logic                in_msg_reg, in_msg_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [BYTE_W-1:0]   bytes_reg [KEEP];
    logic [BYTE_W-1:0]   bytes_next [KEEP];
    logic [BYTE_W-1:0]   view [KEEP];

    logic                accept;
    logic                is_nl;
    logic                last;
    logic                letter_ok;
    logic                all_w;
    logic [SEL_W-1:0]    sel_w;
    logic                chan_ok;
    logic                digits_ok;
    logic [BYTE_W-1:0]   pw_sum;

    assign accept   = req.valid && op_ready;
    assign req.ready = op_ready;
    assign op_valid = req.valid;

    assign is_nl = (req.rx_byte == CH_NL);
    assign last  = is_nl || (count_reg == CNT_W'(MSG_LEN - 1));

    // message as it stands with the current byte folded in
    always_comb
    begin
        for (int k = 0; k < KEEP; k++)
        begin
            if (!is_nl && ({1'b0, count_reg} == (CNT_W+1)'(k)))
                view[k] = req.rx_byte;
            else
                view[k] = bytes_reg[k];
        end
    end

    always_comb
    begin
        letter_ok = 1'b1;
        all_w     = 1'b0;
        sel_w     = SEL_RED;
        case (view[0])
            CH_R:    sel_w = SEL_RED;
            CH_G:    sel_w = SEL_GREEN;
            CH_B:    sel_w = SEL_BLUE;
            CH_A:    all_w = 1'b1;
            default: letter_ok = 1'b0;
        endcase
    end

    assign chan_ok   = letter_ok && (all_w || (int'(sel_w) < NUM_CHANNELS));
    assign digits_ok = is_digit(view[2]) && is_digit(view[3]);
    assign pw_sum    = (view[1][0] ? 8'd100 : 8'd0)
                     + BYTE_W'(view[2][3:0]) * 8'd10
                     + BYTE_W'(view[3][3:0]);

    always_comb
    begin
        op.all    = all_w;
        op.sel    = sel_w;
        op.mant   = view[2][DIGIT_W-1:0];
        op.expo   = view[3][DIGIT_W-1:0];
        op.power  = (pw_sum > BYTE_W'(PWM_STEPS)) ? LEVEL_W'(PWM_STEPS) : pw_sum[LEVEL_W-1:0];
        op.cmd    = CMD_NONE;
        op.status = ST_OK;
        if (!req.req_type)
            op.kind = OP_TICK;
        else if (in_msg_reg && last)
            op.kind = OP_CMD;
        else
            op.kind = OP_NOP;

        if (!chan_ok)
            op.status = ST_BAD_CHAN;
        else if (view[1] == CH_E)
        begin
            if (view[2] == CH_N)
                op.cmd = CMD_RAMP_ON;
            else if (view[2] == CH_F)
                op.cmd = CMD_RAMP_OFF;
            else if (digits_ok)
                op.cmd = CMD_DELAY;
            else
                op.status = ST_BAD_DIGIT;
        end
        else if ((view[1] == CH_ZERO) || (view[1] == CH_ONE))
        begin
            if (digits_ok)
                op.cmd = CMD_POWER;
            else
                op.status = ST_BAD_DIGIT;
        end
        else
            op.status = ST_BAD_SECOND;
    end

    always_comb
    begin
        in_msg_next = in_msg_reg;
        count_next  = count_reg;
        bytes_next  = bytes_reg;
        if (accept && req.req_type)
        begin
            if (!in_msg_reg)
            begin
                if (req.rx_byte == CH_COLON)
                begin
                    in_msg_next = 1'b1;
                    count_next  = '0;
                    for (int k = 0; k < KEEP; k++)
                        bytes_next[k] = '0;
                end
            end
            else if (last)
            begin
                in_msg_next = 1'b0;
                count_next  = '0;
            end
            else
            begin
                count_next = count_reg + 1'b1;
                if ({1'b0, count_reg} < (CNT_W+1)'(KEEP))
                    bytes_next[count_reg[1:0]] = req.rx_byte;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_msg_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            in_msg_reg <= in_msg_next;
            count_reg  <= count_next;
        end
    end

    // message bytes are cleared by the opening colon, not by reset
    always_ff @(posedge clk)
    begin
        bytes_reg <= bytes_next;
    end

endmodule

// ===== rtl/rlpc_fifo.sv =====
// Short op queue between the front end and the execution back end.
module rlpc_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  rlpc_pkg::op_t  wr_data,
    input  logic           wr_valid,
    output logic           wr_ready,
    output rlpc_pkg::op_t  rd_data,
    output logic           rd_valid,
    input  logic           rd_ready
);
    import rlpc_pkg::*;

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    op_t               mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              push, pop;

    assign wr_ready = (count_reg != CNT_W'(FIFO_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(FIFO_DEPTH))
        else $error("queue count above depth");

    a_count_down: assert property (@(posedge clk) disable iff (!rst_n)
        pop && !push |=> count_reg == $past(count_reg) - 1'b1)
        else $error("queue count did not drop on pop");

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count did not rise on push");

endmodule

// ===== rtl/rlpc_back.sv =====
// Back end: executes ticks and commands, holds PWM and ramp state, drives the result register.
module rlpc_back #(
    parameter int NUM_CHANNELS = 3,
    parameter int PWM_STEPS    = 100
) (
    input  logic           clk,
    input  logic           rst_n,
    input  rlpc_pkg::op_t  op,
    input  logic           op_valid,
    output logic           op_ready,
    rlpc_cfg_if.sink       cfg,
    rlpc_rsp_if.source     rsp
);
    import rlpc_pkg::*;

    localparam int CH_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int LIT_W = (NUM_CHANNELS > 3) ? NUM_CHANNELS : 3;

    logic [TICK_W-1:0]   tick_reg, tick_next;
    logic [LEVEL_W-1:0]  phase_reg, phase_next;
    logic [LEVEL_W-1:0]  power_reg [NUM_CHANNELS];
    logic [LEVEL_W-1:0]  power_next [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] enable_reg, enable_next;
    logic [DELAY_W-1:0]  delay_reg, delay_next;
    logic [LEVEL_W-1:0]  level_reg, level_next;
    logic                falling_reg, falling_next;
    logic [CH_W-1:0]     chan_reg, chan_next;
    logic [DELAY_W-1:0]  elapsed_reg, elapsed_next;

    logic                out_valid_reg, out_valid_next;
    logic                red_reg, red_next;
    logic                green_reg, green_next;
    logic                blue_reg, blue_next;
    logic                done_reg, done_next;
    status_t             status_reg, status_next;

    logic                take;
    logic [LIT_W-1:0]    lit;
    logic [DELAY_W:0]    sum;
    logic                step_due;
    logic                found_hi;
    logic [CH_W-1:0]     c_hi, c_lo, c_sel;
    logic [LEVEL_W-1:0]  lvl_w, lvl_adv1, lvl_adv2;
    logic                fall_w, fall_adv1, fall_adv2;

    // one move of the level along the 0..PWM_STEPS..0 walk
    function automatic logic [LEVEL_W:0] advance(input logic [LEVEL_W-1:0] lvl,
                                                 input logic fall);
        logic [LEVEL_W-1:0] l;
        logic               f;
        l = lvl;
        f = fall;
        if (!fall)
        begin
            if (lvl >= LEVEL_W'(PWM_STEPS))
            begin
                f = 1'b1;
                l = LEVEL_W'(PWM_STEPS);
            end
            else
                l = lvl + 1'b1;
        end
        else
        begin
            if (lvl == '0)
                f = 1'b0;
            else
                l = lvl - 1'b1;
        end
        return {f, l};
    endfunction

    assign op_ready  = !out_valid_reg || rsp.ready;
    assign take      = op_valid && op_ready;
    assign cfg.ready = 1'b1;

    assign rsp.valid      = out_valid_reg;
    assign rsp.led_red    = red_reg;
    assign rsp.led_green  = green_reg;
    assign rsp.led_blue   = blue_reg;
    assign rsp.cmd_done   = done_reg;
    assign rsp.cmd_status = status_reg;

    always_comb
    begin
        lit = '0;
        for (int i = 0; i < NUM_CHANNELS; i++)
            lit[i] = (phase_reg < power_reg[i]);
    end

    assign sum      = {1'b0, elapsed_reg} + (DELAY_W+1)'(tick_reg);
    assign step_due = (sum >= {1'b0, delay_reg});

    // next enabled channel at or after the ramp position, and first from zero
    always_comb
    begin
        found_hi = 1'b0;
        c_hi     = '0;
        c_lo     = '0;
        for (int i = NUM_CHANNELS - 1; i >= 0; i--)
        begin
            if (enable_reg[i])
            begin
                c_lo = CH_W'(i);
                if (CH_W'(i) >= chan_reg)
                begin
                    found_hi = 1'b1;
                    c_hi     = CH_W'(i);
                end
            end
        end
    end

    always_comb
    begin
        {fall_adv1, lvl_adv1} = advance(level_reg, falling_reg);
        if (found_hi)
        begin
            c_sel  = c_hi;
            lvl_w  = level_reg;
            fall_w = falling_reg;
        end
        else
        begin
            c_sel  = c_lo;
            lvl_w  = lvl_adv1;
            fall_w = fall_adv1;
        end
        {fall_adv2, lvl_adv2} = advance(lvl_w, fall_w);
    end

    always_comb
    begin
        tick_next      = tick_reg;
        phase_next     = phase_reg;
        power_next     = power_reg;
        enable_next    = enable_reg;
        delay_next     = delay_reg;
        level_next     = level_reg;
        falling_next   = falling_reg;
        chan_next      = chan_reg;
        elapsed_next   = elapsed_reg;
        out_valid_next = out_valid_reg;
        red_next       = red_reg;
        green_next     = green_reg;
        blue_next      = blue_reg;
        done_next      = done_reg;
        status_next    = status_reg;

        if (cfg.valid)
            tick_next = cfg.tick_period_us;

        if (take)
            out_valid_next = 1'b1;
        else if (rsp.ready)
            out_valid_next = 1'b0;

        if (take)
        begin
            red_next    = 1'b0;
            green_next  = 1'b0;
            blue_next   = 1'b0;
            done_next   = 1'b0;
            status_next = ST_OK;
            case (op.kind)
                OP_TICK:
                begin
                    red_next   = lit[0];
                    green_next = lit[1];
                    blue_next  = lit[2];
                    phase_next = (phase_reg == LEVEL_W'(PWM_STEPS - 1)) ? '0
                                                                       : phase_reg + 1'b1;
                    if (enable_reg == '0)
                        elapsed_next = '0;
                    else if (step_due)
                    begin
                        elapsed_next      = '0;
                        power_next[c_sel] = lvl_w;
                        if (c_sel == CH_W'(NUM_CHANNELS - 1))
                        begin
                            chan_next    = '0;
                            level_next   = lvl_adv2;
                            falling_next = fall_adv2;
                        end
                        else
                        begin
                            chan_next    = c_sel + 1'b1;
                            level_next   = lvl_w;
                            falling_next = fall_w;
                        end
                    end
                    else
                        elapsed_next = sum[DELAY_W-1:0];
                end
                OP_CMD:
                begin
                    done_next   = 1'b1;
                    status_next = op.status;
                    if (op.status == ST_OK)
                    begin
                        case (op.cmd)
                            CMD_RAMP_ON:
                                for (int i = 0; i < NUM_CHANNELS; i++)
                                    if (op.all || (int'(op.sel) == i))
                                        enable_next[i] = 1'b1;
                            CMD_RAMP_OFF:
                                for (int i = 0; i < NUM_CHANNELS; i++)
                                    if (op.all || (int'(op.sel) == i))
                                        enable_next[i] = 1'b0;
                            CMD_DELAY:
                                delay_next = DELAY_W'(pow10(op.expo) * DELAY_W'(op.mant));
                            CMD_POWER:
                                for (int i = 0; i < NUM_CHANNELS; i++)
                                    if (op.all || (int'(op.sel) == i))
                                        power_next[i] = op.power;
                            default:
                                ;
                        endcase
                    end
                end
                default:
                    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg      <= TICK_RESET;
            phase_reg     <= '0;
            for (int i = 0; i < NUM_CHANNELS; i++)
                power_reg[i] <= '0;
            enable_reg    <= '0;
            delay_reg     <= DELAY_RESET;
            level_reg     <= '0;
            falling_reg   <= 1'b0;
            chan_reg      <= '0;
            elapsed_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            tick_reg      <= tick_next;
            phase_reg     <= phase_next;
            power_reg     <= power_next;
            enable_reg    <= enable_next;
            delay_reg     <= delay_next;
            level_reg     <= level_next;
            falling_reg   <= falling_next;
            chan_reg      <= chan_next;
            elapsed_reg   <= elapsed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        red_reg    <= red_next;
        green_reg  <= green_next;
        blue_reg   <= blue_next;
        done_reg   <= done_next;
        status_reg <= status_next;
    end

    a_status_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !done_reg |-> status_reg == ST_OK)
        else $error("status set on a result without a finished command");

    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg < LEVEL_W'(PWM_STEPS))
        else $error("pwm phase out of range");

    a_chan_range: assert property (@(posedge clk) disable iff (!rst_n)
        int'(chan_reg) < NUM_CHANNELS)
        else $error("ramp channel out of range");

    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        level_reg <= LEVEL_W'(PWM_STEPS))
        else $error("ramp level above full scale");

endmodule

// ===== verif/rgb_led_pwm_command_controller_top_tb.sv =====
// Self-checking testbench for the RGB LED PWM command controller: directed and random traffic.
module rgb_led_pwm_command_controller_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rlpc_pkg::*;

    // Block configuration, kept in step with the instance below.
    localparam int NCH   = 3;
    localparam int MSGN  = 5;
    localparam int STEPS = 100;

    // Values of req_type.
    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_BYTE = 1'b1;

    // A request reaches its result through the op queue and the result register;
    // a little margin on top before touching the configuration.
    localparam int SETTLE_CYCLES = 4;

    // One result transfer as the checker sees it.
    typedef struct packed {
        logic    red;
        logic    green;
        logic    blue;
        logic    done;
        status_t status;
    } led_result_t;

    logic clk = 1'b0;
    logic rst_n;

    rlpc_req_if req_bus ();
    rlpc_rsp_if rsp_bus ();
    rlpc_cfg_if cfg_bus ();

    rgb_led_pwm_command_controller_top #(
        .NUM_CHANNELS (NCH),
        .MSG_LEN      (MSGN),
        .PWM_STEPS    (STEPS)
    ) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus.sink),
        .rsp   (rsp_bus.source),
        .cfg   (cfg_bus.sink)
    );

    // 8 ns period.
    always #4 clk = ~clk;

    // ------------------------------------------------------------------
    // Shadow copy of the dimmer state. Updated once per accepted request,
    // in request order, so it always matches what the block has been told.
    // ------------------------------------------------------------------
    logic [15:0] period_us;            // microseconds of ramp delay per tick
    logic [6:0]  phase;                // PWM compare phase, 0..STEPS-1
    logic [6:0]  power    [NCH];       // per-channel duty
    logic        ramp_on  [NCH];       // breathing enabled per channel
    logic [33:0] delay_us;             // ramp delay per step
    logic [33:0] elapsed_us;           // delay spent since the last step
    logic [6:0]  level;                // current breathing level
    logic        falling;              // ramp direction
    logic [1:0]  cursor;               // next channel the ramp looks at
    logic [7:0]  msg_buf  [MSGN];      // collected message bytes
    logic [2:0]  msg_cnt;              // bytes collected so far
    logic        collecting;           // inside a message

    // Results still owed by the block, oldest first.
    led_result_t pending_results[$];

    // Run bookkeeping.
    int mismatches    = 0;
    int active_items  = 0;   // requests that did something (ignored bytes excluded)
    int ticks_sent    = 0;
    int ramp_steps    = 0;
    int peak_turns    = 0;
    int period_writes = 0;
    int status_count [4];
    int send_burst    = 0;   // remaining back-to-back requests

    function automatic void reset_model();
        period_us  = TICK_RESET;
        phase      = '0;
        delay_us   = DELAY_RESET;
        elapsed_us = '0;
        level      = '0;
        falling    = 1'b0;
        cursor     = '0;
        msg_cnt    = '0;
        collecting = 1'b0;
        for (int i = 0; i < NCH; i++) begin
            power[i]   = '0;
            ramp_on[i] = 1'b0;
        end
        for (int i = 0; i < MSGN; i++)
            msg_buf[i] = '0;
        for (int i = 0; i < 4; i++)
            status_count[i] = 0;
    endfunction

    function automatic logic is_dec_digit(input logic [7:0] b);
        return b >= CH_ZERO && b <= CH_NINE;
    endfunction

    // Move the ramp past the current channel; a full channel walk moves the level.
    function automatic void ramp_move();
        cursor = cursor + 2'd1;
        if (cursor < NCH)
            return;
        cursor = '0;
        if (!falling) begin
            if (level >= STEPS) begin
                falling = 1'b1;
                level   = STEPS;
                peak_turns++;
            end else begin
                level = level + 7'd1;
            end
        end else begin
            if (level == 0)
                falling = 1'b0;
            else
                level = level - 7'd1;
        end
    endfunction

    // One ramp step: write the level into the next enabled channel.
    function automatic void ramp_take_step();
        if (cursor >= NCH)
            cursor = '0;
        for (int g = 0; g <= 2 * NCH; g++) begin
            if (ramp_on[cursor]) begin
                power[cursor] = level;
                ramp_move();
                return;
            end
            ramp_move();
        end
    endfunction

    // Interpret a completed message; state changes only when it is accepted.
    function automatic status_t run_message();
        int          sel;
        logic        all;
        logic [7:0]  b1;
        logic [7:0]  b2;
        logic [7:0]  b3;
        logic [33:0] d;
        int          pw;
        sel = 0;
        all = 1'b0;
        b1  = msg_buf[1];
        b2  = msg_buf[2];
        b3  = msg_buf[3];
        case (msg_buf[0])
            CH_R:    sel = 0;
            CH_G:    sel = 1;
            CH_B:    sel = 2;
            CH_A:    all = 1'b1;
            default: return ST_BAD_CHAN;
        endcase
        if (!all && sel >= NCH)
            return ST_BAD_CHAN;
        if (b1 == CH_E) begin
            if (b2 == CH_N || b2 == CH_F) begin
                for (int i = 0; i < NCH; i++)
                    if (all || i == sel)
                        ramp_on[i] = (b2 == CH_N);
            end else begin
                if (!is_dec_digit(b2) || !is_dec_digit(b3))
                    return ST_BAD_DIGIT;
                d = 34'(int'(b2) - int'(CH_ZERO));
                for (int p = 0; p < int'(b3) - int'(CH_ZERO); p++)
                    d = d * 34'd10;
                delay_us = d;
            end
            return ST_OK;
        end
        if (b1 == CH_ZERO || b1 == CH_ONE) begin
            if (!is_dec_digit(b2) || !is_dec_digit(b3))
                return ST_BAD_DIGIT;
            pw = 100 * (int'(b1) - int'(CH_ZERO)) + 10 * (int'(b2) - int'(CH_ZERO))
                 + (int'(b3) - int'(CH_ZERO));
            if (pw > STEPS)
                pw = STEPS;
            for (int i = 0; i < NCH; i++)
                if (all || i == sel)
                    power[i] = 7'(pw);
            return ST_OK;
        end
        return ST_BAD_SECOND;
    endfunction

    // Work out the result of one accepted request and queue it.
    function automatic void predict_item(input logic kind, input logic [7:0] b);
        led_result_t r;
        logic        any_on;
        logic [34:0] sum;
        r = '0;
        if (kind == REQ_TICK) begin
            ticks_sent++;
            active_items++;
            r.red   = phase < power[0];
            r.green = phase < power[1];
            r.blue  = phase < power[2];
            phase   = (phase == STEPS - 1) ? 7'd0 : phase + 7'd1;
            any_on  = 1'b0;
            for (int i = 0; i < NCH; i++)
                any_on |= ramp_on[i];
            if (!any_on) begin
                elapsed_us = '0;
            end else begin
                sum = {1'b0, elapsed_us} + 35'(period_us);
                if (sum >= {1'b0, delay_us}) begin
                    ramp_take_step();
                    ramp_steps++;
                    elapsed_us = '0;
                end else begin
                    elapsed_us = sum[33:0];
                end
            end
        end else if (!collecting) begin
            // Outside a message only ':' does anything.
            if (b == CH_COLON) begin
                active_items++;
                collecting = 1'b1;
                msg_cnt    = '0;
                for (int i = 0; i < MSGN; i++)
                    msg_buf[i] = '0;
            end
        end else begin
            active_items++;
            if (b != CH_NL) begin
                if (msg_cnt < MSGN)
                    msg_buf[msg_cnt] = b;
                msg_cnt = msg_cnt + 3'd1;
            end
            if (b == CH_NL || msg_cnt >= MSGN) begin
                r.status = run_message();
                r.done   = 1'b1;
                status_count[r.status]++;
                collecting = 1'b0;
                msg_cnt    = '0;
            end
        end
        pending_results.push_back(r);
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Mostly back to back, some short gaps, a few long ones, and bursts with none.
    function automatic int pick_gap();
        int r;
        if (send_burst > 0) begin
            send_burst--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            send_burst = $urandom_range(30, 200);
            return 0;
        end
        if (r < 70)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 8);
        return $urandom_range(10, 40);
    endfunction

    // Present one request and hold it until the transfer happens.
    // valid is left high afterwards so the next request can follow back to back.
    task automatic send_req(input logic kind, input logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_bus.valid    <= 1'b1;
        req_bus.req_type <= kind;
        req_bus.rx_byte  <= b;
        @(posedge clk);
        while (!req_bus.ready)
            @(posedge clk);
        predict_item(kind, b);
    endtask

    // rx_byte is a don't-care on ticks, so it carries random content.
    task automatic send_tick();
        send_req(REQ_TICK, 8'($urandom_range(0, 255)));
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_req(REQ_BYTE, s[i]);
    endtask

    // Drop valid and wait until every queued result has been delivered.
    task automatic wait_for_results();
        req_bus.valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Block fully idle, then write the tick period.
    task automatic write_tick_period(input logic [15:0] v);
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_bus.valid          <= 1'b1;
        cfg_bus.tick_period_us <= v;
        @(posedge clk);
        while (!cfg_bus.ready)
            @(posedge clk);
        cfg_bus.valid <= 1'b0;
        period_us = v;
        period_writes++;
        @(posedge clk);
    endtask

    function automatic logic [7:0] rand_digit(input int hi);
        return CH_ZERO + 8'($urandom_range(0, hi));
    endfunction

    // A well-formed command with random content; a small share is corrupted.
    task automatic send_random_command();
        logic [7:0] chan;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] b3;
        int         r;
        // a stray ':' may have left a message open; close it first
        if (collecting)
            send_req(REQ_BYTE, CH_NL);
        r = $urandom_range(0, 99);
        if (r < 22)
            chan = CH_R;
        else if (r < 44)
            chan = CH_G;
        else if (r < 66)
            chan = CH_B;
        else if (r < 92)
            chan = CH_A;
        else
            chan = 8'($urandom_range(0, 255));
        b3 = 8'($urandom_range(0, 255));
        r  = $urandom_range(0, 99);
        if (r < 40) begin
            b1 = $urandom_range(0, 1) ? CH_ONE : CH_ZERO;
            b2 = rand_digit(9);
            b3 = rand_digit(9);
        end else if (r < 58) begin
            b1 = CH_E;
            b2 = CH_N;
        end else if (r < 68) begin
            b1 = CH_E;
            b2 = CH_F;
        end else if (r < 92) begin
            b1 = CH_E;
            b2 = rand_digit(9);
            // short delays keep the ramp moving
            b3 = ($urandom_range(0, 99) < 80) ? rand_digit(3) : rand_digit(9);
        end else begin
            b1 = 8'($urandom_range(0, 255));
            b2 = 8'($urandom_range(0, 255));
        end
        if ($urandom_range(0, 9) == 0) begin
            if ($urandom_range(0, 1))
                b2 = 8'($urandom_range(0, 255));
            else
                b3 = 8'($urandom_range(0, 255));
        end
        send_req(REQ_BYTE, CH_COLON);
        send_req(REQ_BYTE, chan);
        send_req(REQ_BYTE, b1);
        send_req(REQ_BYTE, b2);
        if ($urandom_range(0, 99) < 30) begin
            send_req(REQ_BYTE, CH_NL);
        end else begin
            send_req(REQ_BYTE, b3);
            send_req(REQ_BYTE, $urandom_range(0, 1) ? CH_NL : 8'($urandom_range(0, 255)));
        end
    endtask

    // One random phase at a given tick period; pauses once halfway for a full drain.
    task automatic run_random_phase(input logic [15:0] period, input int target);
        int   start;
        int   r;
        logic drained;
        write_tick_period(period);
        start   = active_items;
        drained = 1'b0;
        while (active_items - start < target) begin
            if (!drained && active_items - start >= target / 2) begin
                wait_for_results();
                drained = 1'b1;
            end
            r = $urandom_range(0, 99);
            if (r < 45) begin
                send_random_command();
            end else if (r < 85) begin
                repeat ($urandom_range(1, 12)) send_tick();
            end else if (r < 95) begin
                send_req(REQ_BYTE, 8'($urandom_range(0, 255)));
            end else begin
                // broken message: random bytes, maybe a newline among them
                send_req(REQ_BYTE, CH_COLON);
                repeat ($urandom_range(1, 6)) send_req(REQ_BYTE, 8'($urandom_range(0, 255)));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Power writes: saturation, zero, trailing bytes, LED outputs on ticks.
    task automatic test_power_levels();
        send_req(REQ_BYTE, 8'h00);        // ignored outside a message
        send_req(REQ_BYTE, 8'hFF);
        send_text(":A199\n");             // 199 saturates to full power
        send_tick();
        send_text(":G050Z");              // closed by length, last byte unused
        send_text(":B000\n");
        send_tick();
    endtask

    // Every kind of rejected message.
    task automatic test_rejected_messages();
        send_text(":X\n");                // unknown channel letter
        send_text(":RQ\n");               // bad second character
        send_text(":B1\n");               // power digits missing
        send_text(":REx\n");              // delay with a non-digit
        send_text(":R1:0\n");             // colon stored as data, so a bad digit
    endtask

    // Zero delay steps the ramp every tick: run a full breath, then
    // a second channel, then switch all off and watch the ramp hold.
    task automatic test_ramp_sweep();
        send_text(":RE00\n");
        send_text(":REN\n");
        repeat (230) send_tick();
        send_text(":BEN\n");
        repeat (30) send_tick();
        send_text(":AEF\n");
        repeat (5) send_tick();
    endtask

    // Random traffic across tick period settings, extremes included.
    task automatic test_tick_period_settings();
        run_random_phase(16'd1, 340);
        run_random_phase(16'hFFFF, 340);
        run_random_phase(TICK_RESET, 340);
        run_random_phase(16'($urandom_range(2, 999)), 340);
        run_random_phase(16'($urandom_range(1000, 65534)), 340);
    endtask

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    // Receiver back-pressure: mostly ready, short and long stalls, plus
    // stretches where it never stalls.
    initial begin : rsp_ready_gen
        int stall_left;
        int run_left;
        int r;
        stall_left = 0;
        run_left   = 0;
        rsp_bus.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (run_left > 0) begin
                rsp_bus.ready <= 1'b1;
                run_left--;
            end else if (stall_left > 0) begin
                rsp_bus.ready <= 1'b0;
                stall_left--;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 4) begin
                    run_left = $urandom_range(50, 300);
                    rsp_bus.ready <= 1'b1;
                end else if (r < 20) begin
                    stall_left = $urandom_range(0, 2);
                    rsp_bus.ready <= 1'b0;
                end else if (r < 23) begin
                    stall_left = $urandom_range(9, 39);
                    rsp_bus.ready <= 1'b0;
                end else begin
                    rsp_bus.ready <= 1'b1;
                end
            end
        end
    end

    task automatic note_mismatch(input string what, input led_result_t want,
                                 input led_result_t got);
        mismatches++;
        if (mismatches <= 10)
            $display("[%0t] %s: expected r=%0b g=%0b b=%0b done=%0b status=%0d, got r=%0b g=%0b b=%0b done=%0b status=%0d",
                     $realtime, what, want.red, want.green, want.blue, want.done, want.status,
                     got.red, got.green, got.blue, got.done, got.status);
    endtask

    // Compare every result transfer against the oldest prediction.
    always @(posedge clk) begin : result_checker
        led_result_t got;
        led_result_t want;
        if (rst_n && rsp_bus.valid && rsp_bus.ready) begin
            got.red    = rsp_bus.led_red;
            got.green  = rsp_bus.led_green;
            got.blue   = rsp_bus.led_blue;
            got.done   = rsp_bus.cmd_done;
            got.status = status_t'(rsp_bus.cmd_status);
            if (pending_results.size() == 0) begin
                note_mismatch("result with nothing pending", '0, got);
            end else begin
                want = pending_results.pop_front();
                if (got !== want)
                    note_mismatch("result mismatch", want, got);
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : main_seq
        int waited;
        reset_model();
        rst_n                  <= 1'b0;
        req_bus.valid          <= 1'b0;
        req_bus.req_type       <= REQ_TICK;
        req_bus.rx_byte        <= '0;
        cfg_bus.valid          <= 1'b0;
        cfg_bus.tick_period_us <= TICK_RESET;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_power_levels();
        test_rejected_messages();
        test_ramp_sweep();
        test_tick_period_settings();

        // Drain with a bound, then give the pipeline a few more cycles.
        req_bus.valid <= 1'b0;
        waited = 0;
        while (pending_results.size() != 0 && waited < 20000) begin
            @(posedge clk);
            waited++;
        end
        repeat (10) @(posedge clk);
        if (pending_results.size() != 0) begin
            mismatches += pending_results.size();
            $display("%0d expected results never arrived", pending_results.size());
        end

        $display("Run: %0d transfers (%0d ticks); messages ok %0d, bad channel %0d, bad second %0d, bad digit %0d",
                 active_items, ticks_sent, status_count[ST_OK], status_count[ST_BAD_CHAN],
                 status_count[ST_BAD_SECOND], status_count[ST_BAD_DIGIT]);
        $display("Ramp: %0d steps, %0d turns at full level; %0d tick period writes; %0d mismatches",
                 ramp_steps, peak_turns, period_writes, mismatches);
        if (mismatches == 0) begin
            $display("** rgb_led_pwm_command_controller_top: PASSED **");
        end else begin
            $display("** rgb_led_pwm_command_controller_top: FAILED **");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin : watchdog
        #20_000_000;
        $display("Timeout with %0d results pending", pending_results.size());
        $display("** rgb_led_pwm_command_controller_top: FAILED **");
        $finish;
    end

endmodule
